FILE: hw/rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg: shared types, constants and level table for the sound generator
// Holds the input item type, window codes, register indexes and the
// 32-entry logarithmic level table.
// ----------------------------------------------------------------------------
package psg_pkg;

  localparam int unsigned ClockDivideDefault = 16;
  localparam int unsigned QueueDepth         = 4;

  // Address windows (top three address bits)
  localparam logic [2:0] WinSelect = 3'b110;
  localparam logic [2:0] WinData   = 3'b111;

  // Register indexes
  localparam logic [3:0] RegMixer = 4'd7;
  localparam logic [3:0] RegShape = 4'd13;

  // Classified item handed from front to back
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SELECT = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_NONE   = 2'd3
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data;
  } item_t;

  function automatic logic [15:0] level_q16(input logic [4:0] lvl);
    logic [15:0] v;
    case (lvl)
      5'd0:  v = 16'd0;     5'd1:  v = 16'd0;     5'd2:  v = 16'd438;
      5'd3:  v = 16'd521;   5'd4:  v = 16'd619;   5'd5:  v = 16'd735;
      5'd6:  v = 16'd874;   5'd7:  v = 16'd1039;  5'd8:  v = 16'd1234;
      5'd9:  v = 16'd1467;  5'd10: v = 16'd1744;  5'd11: v = 16'd2072;
      5'd12: v = 16'd2463;  5'd13: v = 16'd2927;  5'd14: v = 16'd3479;
      5'd15: v = 16'd4135;  5'd16: v = 16'd4914;  5'd17: v = 16'd5841;
      5'd18: v = 16'd6942;  5'd19: v = 16'd8250;  5'd20: v = 16'd9806;
      5'd21: v = 16'd11654; 5'd22: v = 16'd13851; 5'd23: v = 16'd16462;
      5'd24: v = 16'd19565; 5'd25: v = 16'd23253; 5'd26: v = 16'd27636;
      5'd27: v = 16'd32845; 5'd28: v = 16'd39037; 5'd29: v = 16'd46395;
      5'd30: v = 16'd55141; 5'd31: v = 16'd65535;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/psg_front.sv
// ----------------------------------------------------------------------------
// psg_front: input decode and item queue
// Classifies each input item (tick, select write, data write, ignored) and
// buffers it in a small FIFO toward the back end.
// ----------------------------------------------------------------------------
module psg_front #(
  parameter int unsigned DEPTH = psg_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_op,
  input  logic [15:0]         in_address,
  input  logic [7:0]          in_value,
  output logic                q_valid,
  input  logic                q_take,
  output psg_pkg::item_t      q_item
);
  import psg_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t            mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  item_t            cls;
  logic             do_push, do_pop;

  // Classify
  always_comb begin
    cls.data = in_value;
    if (!in_op) begin
      cls.kind = KIND_TICK;
    end else if (in_address[15:13] == WinSelect) begin
      cls.kind = KIND_SELECT;
    end else if (in_address[15:13] == WinData) begin
      cls.kind = KIND_DATA;
    end else begin
      cls.kind = KIND_NONE;
    end
  end

  assign in_full = (count_r == (AW+1)'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_take && q_valid;

  // Pointer arithmetic
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= cls;
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH)) else $error("queue overflow");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("count not tracking push");
  a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("pointer skew");
`endif
endmodule

FILE: hw/rtl/psg_back.sv
// ----------------------------------------------------------------------------
// psg_back: generator core and mixer
// Applies one queued item per cycle, unless the two-entry out queue is full,
// to the register file, dividers, noise, envelope; queues the mixed sample.
// ----------------------------------------------------------------------------
module psg_back #(
  parameter int unsigned CLOCK_DIVIDE = psg_pkg::ClockDivideDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_take,
  input  psg_pkg::item_t  q_item,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [17:0]     out_sample
);
  import psg_pkg::*;

  localparam int unsigned PW = (CLOCK_DIVIDE > 1) ? $clog2(CLOCK_DIVIDE) : 1;

  logic [7:0]  regs_r [16];
  logic [7:0]  sel_r;
  logic [PW-1:0] pre_r;
  logic [11:0] tcnt_r [3];
  logic [2:0]  tlev_r;
  logic [4:0]  ncnt_r;
  logic        ntog_r;
  logic [16:0] nsh_r;
  logic [15:0] ecnt_r;
  logic [4:0]  elev_r;
  logic        erise_r;
  logic        ehold_r;

  // Two-entry output skid queue
  logic [17:0] oq_r [2];
  logic        ohead_r;
  logic [1:0]  ocnt_r;

  logic        step, slow, wr_data;
  logic [7:0]  mdata;
  logic [17:0] mix_val;

  assign q_take    = q_valid && (ocnt_r != 2'd2);
  assign step      = q_take;
  assign slow      = step && (q_item.kind == KIND_TICK) && (pre_r == PW'(CLOCK_DIVIDE-1));
  assign wr_data   = step && (q_item.kind == KIND_DATA) && (sel_r[7:4] == 4'd0);
  assign out_empty = (ocnt_r == 2'd0);
  assign out_sample = oq_r[ohead_r];

  // Data write masking
  always_comb begin
    case (sel_r[3:0])
      4'd1, 4'd3, 4'd5, 4'd13: mdata = {4'd0, q_item.data[3:0]};
      4'd6, 4'd8, 4'd9, 4'd10: mdata = {3'd0, q_item.data[4:0]};
      4'd14, 4'd15:            mdata = 8'd0;
      default:                 mdata = q_item.data;
    endcase
  end

  // Next state of generators (computed from current registers)
  logic [11:0] tcnt_nxt [3];
  logic [2:0]  tlev_nxt;
  logic [4:0]  ncnt_nxt;
  logic        ntog_nxt;
  logic [16:0] nsh_nxt;
  logic [15:0] ecnt_nxt;
  logic [4:0]  elev_nxt, elev_adv;
  logic        erise_nxt, erise_adv;
  logic        ehold_nxt, ehold_adv;

  always_comb begin
    logic [11:0] per, inc;
    logic [4:0]  nper, ninc;
    logic [15:0] eper, einc;
    logic [16:0] sh;
    logic [3:0]  shp;
    for (int ch = 0; ch < 3; ch++) begin
      per = {regs_r[ch*2+1][3:0], regs_r[ch*2]};
      if (per == 12'd0) per = 12'd1;
      inc = tcnt_r[ch] + 1'b1;
      if (inc >= per || inc == 12'd0) begin
        tcnt_nxt[ch] = 12'd0;
        tlev_nxt[ch] = ~tlev_r[ch];
      end else begin
        tcnt_nxt[ch] = inc;
        tlev_nxt[ch] = tlev_r[ch];
      end
    end
    nper = regs_r[6][4:0];
    if (nper == 5'd0) nper = 5'd1;
    ninc = ncnt_r + 1'b1;
    ncnt_nxt = ninc;
    ntog_nxt = ntog_r;
    nsh_nxt  = nsh_r;
    sh       = nsh_r;
    if (ninc >= nper || ninc == 5'd0) begin
      ncnt_nxt = 5'd0;
      ntog_nxt = ~ntog_r;
      if (!ntog_r) begin
        sh = {nsh_r[15:0], nsh_r[16] ^ nsh_r[13]};
        nsh_nxt = (sh == 17'd0) ? 17'd1 : sh;
      end
    end
    // Envelope step
    shp = regs_r[RegShape][3:0];
    elev_adv = elev_r; erise_adv = erise_r; ehold_adv = ehold_r;
    if (!ehold_r) begin
      if (erise_r && elev_r < 5'd31) elev_adv = elev_r + 1'b1;
      else if (!erise_r && elev_r > 5'd0) elev_adv = elev_r - 1'b1;
      else if (!shp[3]) begin
        elev_adv = 5'd0; ehold_adv = 1'b1;
      end else if (shp[0]) begin
        if (shp[1]) elev_adv = ~elev_r;
        ehold_adv = 1'b1;
      end else if (shp[1]) erise_adv = ~erise_r;
      else elev_adv = erise_r ? 5'd0 : 5'd31;
    end
    eper = {regs_r[12], regs_r[11]};
    if (eper == 16'd0) eper = 16'd1;
    einc = ecnt_r + 1'b1;
    ecnt_nxt = einc; elev_nxt = elev_r; erise_nxt = erise_r; ehold_nxt = ehold_r;
    if (einc >= eper || einc == 16'd0) begin
      ecnt_nxt = 16'd0;
      elev_nxt = elev_adv; erise_nxt = erise_adv; ehold_nxt = ehold_adv;
    end
  end

  // Control and generator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) regs_r[i] <= 8'd0;
      sel_r   <= 8'd0;
      pre_r   <= '0;
      for (int i = 0; i < 3; i++) tcnt_r[i] <= 12'd0;
      tlev_r  <= 3'd0;
      ncnt_r  <= 5'd0;
      ntog_r  <= 1'b1;
      nsh_r   <= 17'h1FFFF;
      ecnt_r  <= 16'd0;
      elev_r  <= 5'd31;
      erise_r <= 1'b0;
      ehold_r <= 1'b0;
    end else begin
      if (step && q_item.kind == KIND_SELECT) sel_r <= q_item.data;
      if (wr_data) begin
        regs_r[sel_r[3:0]] <= mdata;
        if (sel_r[3:0] == RegShape) begin
          erise_r <= mdata[2];
          elev_r  <= mdata[2] ? 5'd0 : 5'd31;
          ecnt_r  <= 16'd0;
          ehold_r <= 1'b0;
        end
      end
      if (step && q_item.kind == KIND_TICK) begin
        pre_r <= slow ? '0 : pre_r + 1'b1;
      end
      if (slow) begin
        for (int i = 0; i < 3; i++) tcnt_r[i] <= tcnt_nxt[i];
        tlev_r  <= tlev_nxt;
        ncnt_r  <= ncnt_nxt;
        ntog_r  <= ntog_nxt;
        nsh_r   <= nsh_nxt;
        ecnt_r  <= ecnt_nxt;
        elev_r  <= elev_nxt;
        erise_r <= erise_nxt;
        ehold_r <= ehold_nxt;
      end
    end
  end

  // Mixer on the state after the item: build post-item view
  always_comb begin
    logic [7:0]  r7, vol;
    logic [7:0]  vreg [3];
    logic [2:0]  tl;
    logic        nz;
    logic [4:0]  el, lvl;
    r7 = regs_r[RegMixer];
    for (int ch = 0; ch < 3; ch++) vreg[ch] = regs_r[8+ch];
    tl = tlev_r;
    nz = nsh_r[0];
    el = elev_r;
    if (wr_data) begin
      if (sel_r[3:0] == RegMixer) r7 = mdata;
      for (int ch = 0; ch < 3; ch++)
        if (sel_r[3:0] == 4'(8+ch)) vreg[ch] = mdata;
      if (sel_r[3:0] == RegShape) el = mdata[2] ? 5'd0 : 5'd31;
    end
    if (slow) begin
      tl = tlev_nxt;
      nz = nsh_nxt[0];
      el = elev_nxt;
    end
    mix_val = 18'd0;
    for (int ch = 0; ch < 3; ch++) begin
      vol = vreg[ch];
      if (vol[4]) lvl = el;
      else lvl = (vol[3:0] != 4'd0) ? {vol[3:0], 1'b1} : 5'd0;
      if ((r7[ch] || tl[ch]) && (r7[ch+3] || nz))
        mix_val = mix_val + {2'b00, level_q16(lvl)};
    end
  end

  // Output queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ohead_r <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      if (out_pop && !out_empty) ohead_r <= ~ohead_r;
      case ({step, out_pop && !out_empty})
        2'b10:   ocnt_r <= ocnt_r + 1'b1;
        2'b01:   ocnt_r <= ocnt_r - 1'b1;
        default: ocnt_r <= ocnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step) oq_r[ohead_r ^ ocnt_r[0]] <= mix_val;
  end

`ifndef SYNTHESIS
  a_ocnt: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 2'd2) else $error("output queue overflow");
  a_pre: assert property (@(posedge clk) disable iff (!rst_n)
    pre_r <= PW'(CLOCK_DIVIDE-1)) else $error("prescaler out of range");
  a_nsh: assert property (@(posedge clk) disable iff (!rst_n)
    nsh_r != 17'd0) else $error("noise register zero");
`endif
endmodule

FILE: hw/rtl/psg_three_voice_sound_generator_top.sv
// ----------------------------------------------------------------------------
// psg_three_voice_sound_generator_top: three-voice sound generator
// Tone, noise and envelope generators with a log-level mixer.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_op/in_address/in_value and raise in_push; a beat is
//   taken at a clock edge with in_push high and in_full low. in_op low is one
//   CPU tick, high is a bus write (select window 110, data window 111).
//   Output queue: every input beat yields exactly one out_sample, valid while
//   out_empty is low; out_pop takes it.
//   Each beat is first stored in the input queue; the back end then
//   registers its sample into the output queue. Throughput: one beat per
//   cycle while the output queue is not full.
//   Reset (rst_n low, synchronous) clears all generator state and both
//   queues. When the receiver stalls, the two-entry output queue fills, the
//   back end halts, and then the input queue fills and in_full rises; no
//   beat is dropped.
// ----------------------------------------------------------------------------
module psg_three_voice_sound_generator_top #(
  parameter int unsigned CLOCK_DIVIDE = psg_pkg::ClockDivideDefault,
  parameter int unsigned QUEUE_DEPTH  = psg_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [17:0] out_sample
);
  import psg_pkg::*;

  logic  q_valid, q_take;
  item_t q_item;

  psg_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_op, .in_address, .in_value,
    .q_valid, .q_take, .q_item
  );

  psg_back #(.CLOCK_DIVIDE(CLOCK_DIVIDE)) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_item, .out_empty, .out_pop, .out_sample
  );
endmodule

FILE: test/psg_checker.sv
// ----------------------------------------------------------------------------
// psg_checker: sample predictor and scoreboard for the sound generator
// Watches the input and output queues. For every accepted input beat it
// advances its own model of the generator and queues the expected sample.
// Every popped sample is compared against the oldest queued one.
// ----------------------------------------------------------------------------
module psg_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic        in_op,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_value,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [17:0] out_sample,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import psg_pkg::*;

  localparam int unsigned PRESCALE = 16;

  // Register indexes
  localparam int RegNoisePer = 6;
  localparam int RegVolBase  = 8;
  localparam int RegEnvLo    = 11;
  localparam int RegEnvHi    = 12;

  // Level of each of the 32 steps, unsigned 16-bit fraction
  localparam logic [15:0] STEP_LEVEL [32] = '{
    16'd0, 16'd0, 16'd438, 16'd521, 16'd619, 16'd735, 16'd874, 16'd1039,
    16'd1234, 16'd1467, 16'd1744, 16'd2072, 16'd2463, 16'd2927, 16'd3479,
    16'd4135, 16'd4914, 16'd5841, 16'd6942, 16'd8250, 16'd9806, 16'd11654,
    16'd13851, 16'd16462, 16'd19565, 16'd23253, 16'd27636, 16'd32845,
    16'd39037, 16'd46395, 16'd55141, 16'd65535
  };

  // Generator model state
  logic [7:0]  regs [16];
  logic [7:0]  sel_idx;
  logic [3:0]  prescale_cnt;
  logic [11:0] tone_cnt [3];
  logic        tone_out [3];
  logic [4:0]  noise_cnt;
  logic        noise_half;
  logic [16:0] lfsr;
  logic [15:0] env_cnt;
  logic [4:0]  env_lvl;
  logic        env_up;
  logic        env_frozen;

  logic [17:0] sample_q [$];

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic env_restart();
    env_up     = regs[RegShape][2];
    env_lvl    = env_up ? 5'd0 : 5'd31;
    env_cnt    = '0;
    env_frozen = 1'b0;
  endtask

  task automatic env_step();
    logic [3:0] shp;
    shp = regs[RegShape][3:0];
    if (env_frozen) return;
    if (env_up && env_lvl < 5'd31) begin
      env_lvl++;
      return;
    end
    if (!env_up && env_lvl > 5'd0) begin
      env_lvl--;
      return;
    end
    // end of a ramp: stop, hold (maybe flipped), wrap or turn around
    if (!shp[3]) begin
      env_lvl    = 5'd0;
      env_frozen = 1'b1;
    end else if (shp[0]) begin
      if (shp[1]) env_lvl = 5'd31 - env_lvl;
      env_frozen = 1'b1;
    end else if (shp[1]) begin
      env_up = ~env_up;
    end else begin
      env_lvl = env_up ? 5'd0 : 5'd31;
    end
  endtask

  task automatic divided_tick();
    int period;
    logic fb;
    for (int ch = 0; ch < 3; ch++) begin
      period = {regs[2*ch+1][3:0], regs[2*ch]};
      if (period == 0) period = 1;
      tone_cnt[ch] = tone_cnt[ch] + 12'd1;
      if (tone_cnt[ch] >= period || tone_cnt[ch] == 0) begin
        tone_cnt[ch] = '0;
        tone_out[ch] = ~tone_out[ch];
      end
    end
    // noise divider; shift register moves on every second toggle
    period = regs[RegNoisePer][4:0];
    if (period == 0) period = 1;
    noise_cnt = noise_cnt + 5'd1;
    if (noise_cnt >= period || noise_cnt == 0) begin
      noise_cnt  = '0;
      noise_half = ~noise_half;
      if (noise_half) begin
        fb   = lfsr[16] ^ lfsr[13];
        lfsr = {lfsr[15:0], fb};
        if (lfsr == 0) lfsr = 17'd1;
      end
    end
    period = {regs[RegEnvHi], regs[RegEnvLo]};
    if (period == 0) period = 1;
    env_cnt = env_cnt + 16'd1;
    if (env_cnt >= period || env_cnt == 0) begin
      env_cnt = '0;
      env_step();
    end
  endtask

  task automatic bus_store(input logic [15:0] addr, input logic [7:0] data);
    int r;
    if (addr[15:13] == WinSelect) begin
      sel_idx = data;
    end else if (addr[15:13] == WinData && sel_idx < 16) begin
      r = sel_idx;
      case (r)
        1, 3, 5, 13:   data &= 8'h0F;
        6, 8, 9, 10:   data &= 8'h1F;
        14, 15:        data = '0;
        default: ;
      endcase
      regs[r] = data;
      if (r == RegShape) env_restart();
    end
  endtask

  function automatic logic [17:0] mixed_sample();
    logic [17:0] sum;
    logic [7:0]  vol;
    logic [4:0]  lvl;
    sum = '0;
    for (int ch = 0; ch < 3; ch++) begin
      if ((regs[RegMixer][ch] || tone_out[ch]) && (regs[RegMixer][ch+3] || lfsr[0])) begin
        vol = regs[RegVolBase+ch];
        if (vol[4]) lvl = env_lvl;
        else lvl = (vol[3:0] != 0) ? {vol[3:0], 1'b1} : 5'd0;
        sum += STEP_LEVEL[lvl];
      end
    end
    return sum;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Predict on accepted input beats, compare on accepted output beats
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (regs[i]) regs[i] = '0;
      for (int ch = 0; ch < 3; ch++) begin
        tone_cnt[ch] = '0;
        tone_out[ch] = 1'b0;
      end
      sel_idx      = '0;
      prescale_cnt = '0;
      noise_cnt    = '0;
      noise_half   = 1'b1;
      lfsr         = 17'h1FFFF;
      env_restart();
      sample_q.delete();
    end else begin
      if (in_push && !in_full) begin
        if (in_op) begin
          bus_store(in_address, in_value);
        end else if (prescale_cnt + 1 >= PRESCALE) begin
          prescale_cnt = '0;
          divided_tick();
        end else begin
          prescale_cnt++;
        end
        sample_q.push_back(mixed_sample());
      end
      if (out_pop && !out_empty) begin
        if (sample_q.size() == 0)
          report($sformatf("unexpected sample %0d", out_sample));
        else if (out_sample !== sample_q[0])
          report($sformatf("sample got %0d want %0d", out_sample, sample_q[0]));
        if (sample_q.size() != 0) void'(sample_q.pop_front());
      end
    end
    pending = sample_q.size();
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: top-level testbench for the three-voice sound generator
// Drives ticks and bus writes (directed, then random register programming
// with tick bursts) under random push and pop gaps, with one long output
// stall and one full drain. A checker module predicts every sample.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psg_pkg::*;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam int   NUM_BEATS   = 1500;
  localparam int   CYCLE_LIMIT = 400000;
  localparam logic [15:0] SEL_ADDR = 16'hC000;
  localparam logic [15:0] DAT_ADDR = 16'hE000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_op = OP_TICK;
  logic [15:0] in_address = '0;
  logic [7:0]  in_value = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [17:0] out_sample;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          beats_sent = 0;
  bit          gaps_on = 1'b0;
  bit          hold_request = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  psg_three_voice_sound_generator_top uut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_op(in_op), .in_address(in_address), .in_value(in_value),
    .out_empty(out_empty), .out_pop(out_pop), .out_sample(out_sample)
  );

  psg_checker chk (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_op(in_op), .in_address(in_address), .in_value(in_value),
    .out_empty(out_empty), .out_pop(out_pop), .out_sample(out_sample),
    .fail_count(fail_count), .pending(pending)
  );

  // Run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one beat, hold it until taken, then idle a random gap
  task automatic send_beat(input logic op, input logic [15:0] addr, input logic [7:0] val);
    int gap;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    in_push    <= 1'b1;
    in_op      <= op;
    in_address <= addr;
    in_value   <= val;
    @(posedge clk);
    while (in_full) @(posedge clk);
    beats_sent++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Select a register, then write it; low address bits are don't-care
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    send_beat(OP_WRITE, SEL_ADDR | 16'($urandom_range(0, 16'h1FFF)), idx);
    send_beat(OP_WRITE, DAT_ADDR | 16'($urandom_range(0, 16'h1FFF)), val);
  endtask

  // Register value skewed so periods stay short enough to move
  function automatic logic [7:0] pick_value(input int idx);
    case (idx)
      1, 3, 5, 12: return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0;
      0, 2, 4, 6, 11:
        return ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      default: return 8'($urandom);
    endcase
  endfunction

  // Receiver: random pop gaps, plus one long stall on request
  initial begin
    int wait_n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_pop <= 1'b0;
        repeat (120) @(posedge clk);
      end
      wait_n = gaps_on ? $urandom_range(0, 12) : 0;
      if (wait_n > 0) begin
        out_pop <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  initial begin
    int kind;
    int idx;
    int guard;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle ticks, dead windows, bad index, shapes, masked registers
    repeat (3) send_beat(OP_TICK, 16'hFFFF, 8'hFF);
    send_beat(OP_WRITE, 16'h0000, 8'h00);
    send_beat(OP_WRITE, 16'hBFFF, 8'hFF);
    write_reg(8'hFF, 8'hFF);
    write_reg(8'd16, 8'hAA);
    write_reg(8'd14, 8'hFF);
    write_reg(8'd15, 8'hFF);
    write_reg(8'(RegMixer), 8'h00);
    write_reg(8'd8, 8'hFF);
    write_reg(8'd9, 8'h0F);
    write_reg(8'd10, 8'h01);
    write_reg(8'(RegShape), 8'hFE);
    repeat (2) send_beat(OP_TICK, 16'h0000, 8'h00);

    // Random: tick bursts, register programs, stray writes
    while (beats_sent < NUM_BEATS) begin
      if (beats_sent % 100 < 50) gaps_on = (beats_sent / 100) % 3 != 0;
      if (beats_sent >= 500 && beats_sent < 520) hold_request = 1'b1;
      if (beats_sent >= 1000 && beats_sent < 1010) begin
        in_push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        repeat ($urandom_range(1, 40))
          send_beat(OP_TICK, 16'($urandom), 8'($urandom));
      end else if (kind < 9) begin
        idx = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
        write_reg(8'(idx), pick_value(idx));
      end else begin
        send_beat(OP_WRITE, 16'($urandom), 8'($urandom));
      end
    end
    in_push <= 1'b0;

    // Drain, then let the pipeline settle
    guard = 0;
    while (pending != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
